// ===== design/lzrle_pkg.sv =====
// Package for the LZ/RLE token decompressor: shared constants, codes and the
// command struct passed from the decode core to the result packer.
// No dependencies.
`default_nettype none
package lzrle_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int OUTPUT_LIMIT_DEF = 49152;
  localparam int KEY_DEPTH        = 128;
  localparam int KEY_AW           = 7;
  localparam int TOTAL_W          = 16;

  localparam logic [KEY_AW-1:0] KEY_IDX_SLOT = 7'h6e;

  localparam logic IDX_PROTECTED = 1'b0;
  localparam logic IDX_LAST_BYTE = 1'b1;

  localparam logic KIND_STREAM = 1'b0;
  localparam logic KIND_KEY    = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADREF = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  typedef struct packed {
    logic       push;
    logic       fin;
    logic [7:0] data;
    logic [1:0] status;
  } pk_cmd_t;

endpackage
`default_nettype wire

// ===== design/lzrle_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lzrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/lzrle_packer.sv =====
// Result packer: gathers decoded bytes into beats of up to four and holds
// the output register. Depends on lzrle_pkg.
`default_nettype none
module lzrle_packer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lzrle_pkg::pk_cmd_t cmd,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte0,
  output logic [7:0]             out_byte1,
  output logic [7:0]             out_byte2,
  output logic [7:0]             out_byte3,
  output logic [2:0]             out_count,
  output logic                   out_last,
  output logic [1:0]             out_status
);

  logic [7:0] acc_r [4];
  logic [7:0] acc_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r [4];
  logic [7:0] ob_nxt [4];
  logic [2:0] oc_r, oc_nxt;
  logic       ol_r, ol_nxt;
  logic [1:0] os_r, os_nxt;
  logic       need_flush, can_flush, take;

  assign need_flush = (cmd.push && cnt_r == 3'd4) ||
                      (cmd.fin && (cnt_r != 3'd0 || cmd.status != lzrle_pkg::ST_OK));
  assign can_flush  = !ov_r || !out_stall;
  assign ready      = !need_flush || can_flush;
  assign take       = (cmd.push || cmd.fin) && ready;

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    ov_nxt  = ov_r && out_stall;
    ob_nxt  = ob_r;
    oc_nxt  = oc_r;
    ol_nxt  = ol_r;
    os_nxt  = os_r;
    if (take) begin
      if (need_flush) begin
        ov_nxt = 1'b1;
        ob_nxt = acc_r;
        oc_nxt = cnt_r;
        ol_nxt = cmd.fin;
        os_nxt = cmd.status;
      end
      if (cmd.push) begin
        if (need_flush || cnt_r == 3'd0) begin
          acc_nxt = '{cmd.data, 8'h00, 8'h00, 8'h00};
          cnt_nxt = 3'd1;
        end else begin
          acc_nxt[cnt_r[1:0]] = cmd.data;
          cnt_nxt = cnt_r + 3'd1;
        end
      end else begin
        acc_nxt = '{8'h00, 8'h00, 8'h00, 8'h00};
        cnt_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ob_r  <= ob_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
    os_r  <= os_nxt;
    if (!rst_n) begin
      cnt_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_byte0  = ob_r[0];
  assign out_byte1  = ob_r[1];
  assign out_byte2  = ob_r[2];
  assign out_byte3  = ob_r[3];
  assign out_count  = oc_r;
  assign out_last   = ol_r;
  assign out_status = os_r;

endmodule
`default_nettype wire

// ===== design/lzrle_core.sv =====
// Decode core: token state machine, history and key memory sequencing,
// configuration registers. Depends on lzrle_pkg; drives two lzrle_ram.
`default_nettype none
module lzrle_core #(
  parameter int WINDOW_DEPTH = lzrle_pkg::WINDOW_DEPTH_DEF,
  parameter int OUTPUT_LIMIT = lzrle_pkg::OUTPUT_LIMIT_DEF,
  localparam int HAW = $clog2(WINDOW_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [7:0]              cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_kind,
  input  wire logic [7:0]              in_data_byte,
  input  wire logic [6:0]              in_key_slot,
  input  wire logic [7:0]              in_key_value,
  output logic                         h_we,
  output logic [HAW-1:0]               h_waddr,
  output logic [7:0]                   h_wdata,
  output logic                         h_re,
  output logic [HAW-1:0]               h_raddr,
  input  wire logic [7:0]              h_rdata,
  output logic                         k_we,
  output logic [lzrle_pkg::KEY_AW-1:0] k_waddr,
  output logic [7:0]                   k_wdata,
  output logic                         k_re,
  output logic [lzrle_pkg::KEY_AW-1:0] k_raddr,
  input  wire logic [7:0]              k_rdata,
  output lzrle_pkg::pk_cmd_t           pk_cmd,
  input  wire logic                    pk_ready
);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_CRD, S_CWR, S_KRD, S_KIDX, S_KUSE, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    P_TOKEN, P_REF_LO, P_REF_LEN, P_FILL_BYTE, P_FILL_EXT, P_LIT, P_LIT_EXT, P_PASS
  } phase_t;

  localparam int TW = lzrle_pkg::TOTAL_W;
  localparam logic [TW:0] LIMIT = (TW+1)'(OUTPUT_LIMIT);

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [7:0]          tok_r, tok_nxt;
  logic [11:0]         dist_r, dist_nxt;
  logic [7:0]          remain_r, remain_nxt;
  logic                ext_r, ext_nxt;
  logic [7:0]          fill_r, fill_nxt;
  logic                failed_r, failed_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [7:0]          cnt_r, cnt_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [6:0]          idx_r, idx_nxt;
  logic                prot_r, lastb_wr;
  logic [7:0]          lastb_r;

  logic                accept;
  logic [7:0]          d;
  logic [7:0]          len_sel;
  logic                is_copy, is_key;
  logic [TW:0]         room, sum;
  logic [7:0]          clip;
  logic [TW:0]         cp_addr;
  logic [6:0]          idx_inc;
  logic [7:0]          key;

  assign accept  = in_valid && state_r == S_IDLE;
  assign d       = in_data_byte;
  assign in_stall = state_r != S_IDLE;
  assign room    = LIMIT - {1'b0, total_r};
  assign clip    = (room < {{(TW-7){1'b0}}, len_sel}) ? room[7:0] : len_sel;
  assign sum     = {1'b0, total_r} + {{(TW-7){1'b0}}, clip};
  assign cp_addr = {1'b0, total_r} - {{(TW-11){1'b0}}, dist_r} - (TW+1)'(1);
  assign idx_inc = k_rdata[6:0] + 7'd1;
  assign key     = (idx_r == lzrle_pkg::KEY_IDX_SLOT) ? {1'b0, idx_r} : k_rdata;
  assign lastb_wr = cfg_we && cfg_index == lzrle_pkg::IDX_LAST_BYTE;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    tok_nxt    = tok_r;
    dist_nxt   = dist_r;
    remain_nxt = remain_r;
    ext_nxt    = ext_r;
    fill_nxt   = fill_r;
    failed_nxt = failed_r;
    total_nxt  = total_r;
    cnt_nxt    = cnt_r;
    byte_nxt   = byte_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    len_sel    = 8'd0;
    is_copy    = 1'b0;
    is_key     = 1'b0;
    h_we       = 1'b0;
    h_waddr    = total_r[HAW-1:0];
    h_wdata    = byte_r;
    h_re       = 1'b0;
    h_raddr    = cp_addr[HAW-1:0];
    k_we       = 1'b0;
    k_waddr    = in_key_slot;
    k_wdata    = in_key_value;
    k_re       = 1'b0;
    k_raddr    = lzrle_pkg::KEY_IDX_SLOT;
    pk_cmd     = '{push: 1'b0, fin: 1'b0, data: byte_r, status: status_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == lzrle_pkg::KIND_KEY) begin
            k_we = 1'b1;
          end else if (failed_r) begin
            status_nxt = lzrle_pkg::ST_BADREF;
            state_nxt  = S_FIN;
          end else if ({1'b0, total_r} >= LIMIT) begin
            status_nxt = lzrle_pkg::ST_LIMIT;
            state_nxt  = S_FIN;
          end else begin
            case (phase_r)
              P_TOKEN: begin
                if (d == 8'd0) begin
                  byte_nxt  = lastb_r;
                  len_sel   = 8'd1;
                  phase_nxt = P_PASS;
                end else if (d[0]) begin
                  tok_nxt   = d;
                  phase_nxt = P_REF_LO;
                end else if (d[1]) begin
                  tok_nxt   = d;
                  phase_nxt = P_FILL_BYTE;
                end else begin
                  remain_nxt = {2'b00, d[7:2]};
                  ext_nxt    = d[7:2] == 6'd63;
                  phase_nxt  = P_LIT;
                end
              end
              P_REF_LO: begin
                dist_nxt = {tok_r[4:1], d};
                if (tok_r[7:5] == 3'd7) begin
                  phase_nxt = P_REF_LEN;
                end else begin
                  phase_nxt = P_TOKEN;
                  is_copy   = 1'b1;
                  len_sel   = 8'd3 + {5'd0, tok_r[7:5]};
                end
              end
              P_REF_LEN: begin
                phase_nxt = P_TOKEN;
                is_copy   = 1'b1;
                len_sel   = d;
              end
              P_FILL_BYTE: begin
                fill_nxt  = d;
                byte_nxt  = d;
                len_sel   = {2'b00, tok_r[7:2]} + 8'd3;
                phase_nxt = (tok_r[7:2] == 6'd63) ? P_FILL_EXT : P_TOKEN;
              end
              P_FILL_EXT: begin
                byte_nxt  = fill_r;
                len_sel   = d;
                phase_nxt = (d == 8'hff) ? P_FILL_EXT : P_TOKEN;
              end
              P_LIT: begin
                byte_nxt = d;
                len_sel  = 8'd1;
                is_key   = prot_r;
                if (remain_r > 8'd0) begin
                  remain_nxt = remain_r - 8'd1;
                end
                if (remain_r <= 8'd1) begin
                  phase_nxt = ext_r ? P_LIT_EXT : P_TOKEN;
                end
              end
              P_LIT_EXT: begin
                if (d == 8'd0) begin
                  phase_nxt = P_TOKEN;
                end else begin
                  remain_nxt = d;
                  ext_nxt    = d == 8'hff;
                  phase_nxt  = P_LIT;
                end
              end
              P_PASS: begin
                byte_nxt = d;
                len_sel  = 8'd1;
              end
              default: begin
                phase_nxt = P_TOKEN;
              end
            endcase
            cnt_nxt    = clip;
            status_nxt = (sum >= LIMIT) ? lzrle_pkg::ST_LIMIT : lzrle_pkg::ST_OK;
            if (is_copy) begin
              // Distance reaching before the first written byte: fail and stop.
              if ({{(TW-11){1'b0}}, dist_nxt} + (TW+1)'(1) > {1'b0, total_r}) begin
                failed_nxt = 1'b1;
                status_nxt = lzrle_pkg::ST_BADREF;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_CRD;
              end
            end else if (is_key) begin
              state_nxt = S_KRD;
            end else begin
              state_nxt = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        if (cnt_r == 8'd0) begin
          state_nxt = S_FIN;
        end else begin
          pk_cmd.push = 1'b1;
          if (pk_ready) begin
            h_we      = 1'b1;
            total_nxt = total_r + TW'(1);
            cnt_nxt   = cnt_r - 8'd1;
          end
        end
      end
      S_CRD: begin
        if (cnt_r == 8'd0) begin
          state_nxt = S_FIN;
        end else begin
          h_re      = 1'b1;
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        pk_cmd.push = 1'b1;
        pk_cmd.data = h_rdata;
        h_wdata     = h_rdata;
        if (pk_ready) begin
          h_we      = 1'b1;
          total_nxt = total_r + TW'(1);
          cnt_nxt   = cnt_r - 8'd1;
          state_nxt = S_CRD;
        end
      end
      S_KRD: begin
        k_re      = 1'b1;
        state_nxt = S_KIDX;
      end
      S_KIDX: begin
        k_we      = 1'b1;
        k_waddr   = lzrle_pkg::KEY_IDX_SLOT;
        k_wdata   = {1'b0, idx_inc};
        k_re      = 1'b1;
        k_raddr   = idx_inc;
        idx_nxt   = idx_inc;
        state_nxt = S_KUSE;
      end
      S_KUSE: begin
        byte_nxt  = byte_r ^ key;
        state_nxt = S_RUN;
      end
      S_FIN: begin
        pk_cmd.fin = 1'b1;
        if (pk_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    fill_r <= fill_nxt;
    cnt_r  <= cnt_nxt;
    byte_r <= byte_nxt;
    idx_r  <= idx_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= P_TOKEN;
      tok_r    <= 8'd0;
      remain_r <= 8'd0;
      ext_r    <= 1'b0;
      failed_r <= 1'b0;
      total_r  <= '0;
      status_r <= lzrle_pkg::ST_OK;
      prot_r   <= 1'b0;
      lastb_r  <= 8'd0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      tok_r    <= tok_nxt;
      remain_r <= remain_nxt;
      ext_r    <= ext_nxt;
      failed_r <= failed_nxt;
      total_r  <= total_nxt;
      status_r <= status_nxt;
      if (cfg_we && cfg_index == lzrle_pkg::IDX_PROTECTED) begin
        prot_r <= cfg_wdata[0];
      end
      if (lastb_wr) begin
        lastb_r <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lz_rle_token_decompressor_top.sv =====
// A key beat just writes the key RAM; a status-only stream beat just sends the
// end command; any other stream beat holds the input while its fill, literal,
// pass-through or copied bytes go out, each keyed literal after a key index step.
// One beat in flight, up to 255 bytes (64 results); output stalls also hold it.
// Reset (rst_n low, synchronous) clears control state and the output valid; the
// history and key RAMs need no clearing pass. Uses lzrle_pkg, core, packer, ram.
`default_nettype none
module lz_rle_token_decompressor_top #(
  parameter int WINDOW_DEPTH = lzrle_pkg::WINDOW_DEPTH_DEF,
  parameter int OUTPUT_LIMIT = lzrle_pkg::OUTPUT_LIMIT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [6:0] in_key_slot,
  input  wire logic [7:0] in_key_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte0,
  output logic [7:0]      out_byte1,
  output logic [7:0]      out_byte2,
  output logic [7:0]      out_byte3,
  output logic [2:0]      out_count,
  output logic            out_last,
  output logic [1:0]      out_status
);

  localparam int HAW = $clog2(WINDOW_DEPTH);

  // History RAM ports: written once per decoded byte, read for back-refs.
  logic           h_we, h_re;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [7:0]     h_wdata, h_rdata;

  // Key RAM ports: loaded by key beats; the index slot is stepped in place.
  logic                        k_we, k_re;
  logic [lzrle_pkg::KEY_AW-1:0] k_waddr, k_raddr;
  logic [7:0]                  k_wdata, k_rdata;

  // Byte and end-of-beat commands from the core to the packer.
  lzrle_pkg::pk_cmd_t pk_cmd;
  logic               pk_ready;

  lzrle_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .OUTPUT_LIMIT(OUTPUT_LIMIT)
  ) u_core (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_kind, .in_data_byte, .in_key_slot, .in_key_value,
    .h_we, .h_waddr, .h_wdata, .h_re, .h_raddr, .h_rdata,
    .k_we, .k_waddr, .k_wdata, .k_re, .k_raddr, .k_rdata,
    .pk_cmd, .pk_ready
  );

  lzrle_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  lzrle_ram #(.WIDTH(8), .DEPTH(lzrle_pkg::KEY_DEPTH)) u_key (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

  // Hold a full group of four until the next byte or the end of the beat
  // shows whether it is the last result.
  lzrle_packer u_pack (
    .clk, .rst_n, .cmd(pk_cmd), .ready(pk_ready),
    .out_valid, .out_stall, .out_byte0, .out_byte1, .out_byte2, .out_byte3,
    .out_count, .out_last, .out_status
  );

endmodule
`default_nettype wire

// ===== design/lzrle_checker.sv =====
// Port-level checker for the decompressor top level, with its bind.
// Depends on lzrle_pkg and lz_rle_token_decompressor_top.
`default_nettype none
module lzrle_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte0,
  input wire logic [2:0] out_count,
  input wire logic       out_last,
  input wire logic [1:0] out_status
);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= 3'd4)
    else $error("count above four");

  a_empty_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == 3'd0 |-> out_last && out_status != lzrle_pkg::ST_OK)
    else $error("empty result without status");

  a_nonlast_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_count == 3'd4)
    else $error("partial result before last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte0) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind lz_rle_token_decompressor_top lzrle_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_byte0, .out_count, .out_last, .out_status
);
`default_nettype wire

// ===== verif/lzrle_checker.sv =====
// Scoreboard for the LZ/RLE token decompressor: watches the input, result and
// register ports, predicts every result beat and compares it field by field.
// Depends on lzrle_pkg.
`timescale 1ns / 100ps
module lzrle_scoreboard #(
  parameter int WINDOW = lzrle_pkg::WINDOW_DEPTH_DEF,
  parameter int LIMIT  = lzrle_pkg::OUTPUT_LIMIT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [6:0] in_key_slot,
  input  wire logic [7:0] in_key_value,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte0,
  input  wire logic [7:0] out_byte1,
  input  wire logic [7:0] out_byte2,
  input  wire logic [7:0] out_byte3,
  input  wire logic [2:0] out_count,
  input  wire logic       out_last,
  input  wire logic [1:0] out_status,
  output int              fail_count,
  output int              pending,
  output int              bytes_made,
  output int              beats_checked
);

  typedef enum logic [3:0] {
    PH_TOKEN, PH_REF_LO, PH_REF_LEN, PH_FILL_BYTE, PH_FILL_EXT, PH_LIT, PH_LIT_EXT, PH_PASS
  } phase_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] cnt;
    logic       last;
    logic [1:0] st;
  } word_t;

  logic [7:0]  window_mem [WINDOW];
  logic [7:0]  keys [lzrle_pkg::KEY_DEPTH];
  int unsigned made;
  phase_t      ph;
  logic [7:0]  tok, left, fill_val, end_byte;
  logic [11:0] dist_hold;
  bit          ext_mark, protect, failed;
  logic [7:0]  burst [$];
  word_t       words_q [$];
  int          fails, checked;

  task push_byte(input logic [7:0] b);
    if (made >= LIMIT || burst.size() >= 256) return;
    window_mem[made % WINDOW] = b;
    burst.push_back(b);
    made++;
  endtask

  function logic [7:0] next_key();
    logic [6:0] idx;
    if (!protect) return 8'h00;
    idx = keys[lzrle_pkg::KEY_IDX_SLOT][6:0] + 7'd1;
    keys[lzrle_pkg::KEY_IDX_SLOT] = {1'b0, idx};
    return keys[idx];
  endfunction

  task copy_back(input int unsigned len);
    int unsigned span;
    span = dist_hold + 1;
    if (span > made) begin
      failed = 1;
      return;
    end
    for (int unsigned i = 0; i < len && made < LIMIT; i++)
      push_byte(window_mem[(made - span) % WINDOW]);
  endtask

  task run_fill(input int unsigned len);
    for (int unsigned i = 0; i < len && made < LIMIT; i++) push_byte(fill_val);
  endtask

  task decode_byte(input logic [7:0] d);
    int unsigned n;
    case (ph)
      PH_TOKEN: begin
        if (d == 8'h00) begin
          push_byte(end_byte);
          ph = PH_PASS;
        end else if (d[0]) begin
          tok = d;
          ph = PH_REF_LO;
        end else if (d[1]) begin
          tok = d;
          ph = PH_FILL_BYTE;
        end else begin
          left = {2'b00, d[7:2]};
          ext_mark = (left == 8'd63);
          ph = PH_LIT;
        end
      end
      PH_REF_LO: begin
        dist_hold = {tok[4:1], d};
        if (tok[7:5] == 3'b111) ph = PH_REF_LEN;
        else begin
          ph = PH_TOKEN;
          copy_back(3 + tok[7:5]);
        end
      end
      PH_REF_LEN: begin
        ph = PH_TOKEN;
        copy_back(d);
      end
      PH_FILL_BYTE: begin
        fill_val = d;
        n = tok[7:2] + 3;
        run_fill(n);
        ph = (n == 66) ? PH_FILL_EXT : PH_TOKEN;
      end
      PH_FILL_EXT: begin
        run_fill(d);
        ph = (d == 8'hff) ? PH_FILL_EXT : PH_TOKEN;
      end
      PH_LIT: begin
        push_byte(d ^ next_key());
        if (left > 0) left--;
        if (left == 0) ph = ext_mark ? PH_LIT_EXT : PH_TOKEN;
      end
      PH_LIT_EXT: begin
        if (d == 8'h00) ph = PH_TOKEN;
        else begin
          left = d;
          ext_mark = (d == 8'hff);
          ph = PH_LIT;
        end
      end
      PH_PASS: push_byte(d);
      default: ph = PH_TOKEN;
    endcase
  endtask

  // Turn one stream beat into its expected result beats.
  task predict_stream(input logic [7:0] d);
    logic [1:0] st;
    int nres, cnt;
    word_t w;
    burst.delete();
    if (!failed && made < LIMIT) decode_byte(d);
    st = failed ? lzrle_pkg::ST_BADREF :
         (made >= LIMIT ? lzrle_pkg::ST_LIMIT : lzrle_pkg::ST_OK);
    nres = (burst.size() + 3) / 4;
    if (nres == 0 && st != lzrle_pkg::ST_OK) nres = 1;
    for (int r = 0; r < nres; r++) begin
      cnt = burst.size() - r * 4;
      if (cnt > 4) cnt = 4;
      if (cnt < 0) cnt = 0;
      w.b0 = (cnt > 0) ? burst[r*4]   : 8'h00;
      w.b1 = (cnt > 1) ? burst[r*4+1] : 8'h00;
      w.b2 = (cnt > 2) ? burst[r*4+2] : 8'h00;
      w.b3 = (cnt > 3) ? burst[r*4+3] : 8'h00;
      w.cnt = cnt[2:0];
      w.last = (r + 1 == nres);
      w.st = st;
      words_q.push_back(w);
    end
  endtask

  task check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      made = 0; ph = PH_TOKEN; tok = 0; dist_hold = 0; left = 0; fill_val = 0;
      ext_mark = 0; protect = 0; end_byte = 0; failed = 0;
      words_q.delete();
      for (int i = 0; i < lzrle_pkg::KEY_DEPTH; i++) keys[i] = 8'h00;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lzrle_pkg::IDX_PROTECTED) protect = cfg_wdata[0];
        else end_byte = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        if (in_kind == lzrle_pkg::KIND_KEY) keys[in_key_slot] = in_key_value;
        else predict_stream(in_data_byte);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (words_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fails++;
        end else begin
          w = words_q.pop_front();
          check_field("byte0", w.b0, out_byte0);
          check_field("byte1", w.b1, out_byte1);
          check_field("byte2", w.b2, out_byte2);
          check_field("byte3", w.b3, out_byte3);
          check_field("count", {5'd0, w.cnt}, {5'd0, out_count});
          check_field("last", {7'd0, w.last}, {7'd0, out_last});
          check_field("status", {6'd0, w.st}, {6'd0, out_status});
        end
      end
    end
    fail_count    <= fails;
    pending       <= words_q.size();
    bytes_made    <= made;
    beats_checked <= checked;
  end

  initial begin
    fails = 0;
    checked = 0;
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the decompressor testbench: clock, reset, stimulus and verdict.
// Instantiates lz_rle_token_decompressor_top and lzrle_scoreboard; uses lzrle_pkg.
`timescale 1ns / 100ps
module testbench;

  // Generous cap, well above what the limit run and the decode phases under
  // receiver pressure need.
  localparam int CYCLE_CAP = 2_000_000;
  localparam int LIMIT     = lzrle_pkg::OUTPUT_LIMIT_DEF;

  logic       clk, rst_n;
  logic       cfg_we, cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid, in_stall, in_kind;
  logic [7:0] in_data_byte, in_key_value;
  logic [6:0] in_key_slot;
  logic       out_valid, out_stall;
  logic [7:0] out_byte0, out_byte1, out_byte2, out_byte3;
  logic [2:0] out_count;
  logic       out_last;
  logic [1:0] out_status;

  int fail_count, pending, bytes_made, beats_checked;
  int send_pct, stall_pct;
  int cycles, beats_sent;
  int fill_left;
  bit long_hold_req;

  lz_rle_token_decompressor_top dut (.*);

  lzrle_scoreboard #(.WINDOW(lzrle_pkg::WINDOW_DEPTH_DEF), .LIMIT(LIMIT)) scoreboard (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("lz_rle_token_decompressor_top: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked for one, counted here.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left = 400;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else
        out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one beat, with a random gap first; hold it until taken.
  task send_beat(input logic kind, input logic [7:0] d, input logic [6:0] slot,
                 input logic [7:0] val);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= d;
    in_key_slot  <= slot;
    in_key_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task send_byte(input logic [7:0] d);
    send_beat(lzrle_pkg::KIND_STREAM, d, 7'($urandom), 8'($urandom));
  endtask

  task send_key(input logic [6:0] slot, input logic [7:0] val);
    send_beat(lzrle_pkg::KIND_KEY, 8'($urandom), slot, val);
  endtask

  // Drain: drop valid, wait for every expected beat, then let quiet work finish.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_reg(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task literal_run(input int n);
    int e;
    send_byte({n[5:0], 2'b00});
    repeat (n) send_byte(8'($urandom));
    if (n != 63) return;
    forever begin
      e = ($urandom_range(39) == 0) ? 255 : $urandom_range(8);
      send_byte(e[7:0]);
      if (e == 0) return;
      repeat (e) send_byte(8'($urandom));
      if (e != 255) return;
    end
  endtask

  task fill_run(input int m, input logic [7:0] val);
    int e;
    send_byte({m[5:0], 2'b10});
    send_byte(val);
    if (m != 63) return;
    do begin
      e = ($urandom_range(4) == 0) ? 255 : $urandom_range(254);
      send_byte(e[7:0]);
    end while (e == 255);
  endtask

  // Back-reference that stays inside what has been written so far.
  task back_ref(input int code, input int len_byte);
    int top_d;
    logic [11:0] dm1;
    top_d = (bytes_made < 4096) ? bytes_made : 4096;
    if (top_d == 0) begin
      literal_run(2);
      return;
    end
    if ($urandom_range(1)) dm1 = 12'($urandom_range((top_d < 16 ? top_d : 16) - 1));
    else dm1 = 12'($urandom_range(top_d - 1));
    send_byte({code[2:0], dm1[11:8], 1'b1});
    send_byte(dm1[7:0]);
    if (code == 7) send_byte(len_byte[7:0]);
  endtask

  task random_tokens(input int n_beats);
    int stop_at, pick;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 5) send_key(7'($urandom), 8'($urandom));
      else if (pick < 35) literal_run($urandom_range(3) == 0 ? 63 : $urandom_range(1, 12));
      else if (pick < 60) fill_run($urandom_range(3) == 0 ? 63 : $urandom_range(62),
                                   8'($urandom));
      else back_ref($urandom_range(7), $urandom_range(255));
    end
  endtask

  initial begin
    cycles = 0; beats_sent = 0; long_hold_req = 0; fill_left = 0;
    send_pct = 0; stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = lzrle_pkg::IDX_PROTECTED; cfg_wdata = 8'h00;
    in_valid = 1'b0; in_kind = lzrle_pkg::KIND_STREAM; in_data_byte = 8'h00;
    in_key_slot = 7'h00; in_key_value = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every key slot first so that no literal reads an empty one.
    for (int s = 0; s < lzrle_pkg::KEY_DEPTH; s++)
      send_key(s[6:0], s == 0 ? 8'h00 :
               (s == lzrle_pkg::KEY_DEPTH - 1 ? 8'hff : 8'($urandom)));
    drain();
    write_reg(lzrle_pkg::IDX_PROTECTED, 8'h00);
    write_reg(lzrle_pkg::IDX_LAST_BYTE, 8'ha5);

    // Directed: field extremes, each token kind, short and extended lengths.
    send_byte(8'h08);                // two literals
    send_byte(8'h00);
    send_byte(8'hff);
    fill_run(0, 8'hff);              // shortest fill
    back_ref(0, 0);                  // shortest copy
    back_ref(7, 0);                  // extended copy of length zero
    back_ref(7, 255);                // longest copy
    send_byte({6'd63, 2'b10});       // fill that takes an extension byte
    send_byte(8'h00);
    send_byte(8'h00);                // zero extension of a long fill right away
    drain();
    write_reg(lzrle_pkg::IDX_PROTECTED, 8'h01);
    send_byte(8'h0c);                // three keyed literals
    repeat (3) send_byte(8'($urandom));
    send_key(lzrle_pkg::KEY_IDX_SLOT, 8'h7f);   // move the key index to the wrap point
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'hff);
    drain();

    // Phase one: sender rarely idles, receiver often stalls.
    write_reg(lzrle_pkg::IDX_LAST_BYTE, 8'h00);
    send_pct = 7; stall_pct = 64;
    random_tokens(50);
    drain();

    // Phase two: the other way round, opening with a long hold-off.
    write_reg(lzrle_pkg::IDX_PROTECTED, 8'h00);
    write_reg(lzrle_pkg::IDX_LAST_BYTE, 8'hff);
    send_pct = 64; stall_pct = 7;
    long_hold_req = 1;
    random_tokens(50);
    drain();

    // Phase three: no idling; fill towards the output limit, end the data,
    // then pass raw bytes through until the limit cuts them off.
    write_reg(lzrle_pkg::IDX_PROTECTED, 8'h01);
    write_reg(lzrle_pkg::IDX_LAST_BYTE, 8'($urandom));
    send_pct = 0; stall_pct = 0;
    random_tokens(20);
    send_byte({6'd63, 2'b10});
    send_byte(8'($urandom));
    // The block is busy with the fill; the wait below lets the byte count settle.
    @(posedge clk);
    while (bytes_made + 255 + 40 <= LIMIT) begin
      send_byte(8'hff);
      @(posedge clk);
    end
    fill_left = LIMIT - 40 - bytes_made;
    send_byte(fill_left[7:0]);       // close the fill 40 bytes short of the limit
    send_byte(8'h00);                // end token
    while (bytes_made < LIMIT) send_byte(8'($urandom));
    repeat (8) send_byte(8'($urandom));

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d beats in: key loads, literals, fills, copies, end token,",
             beats_sent);
    $display("pass-through and the output limit; %0d result beats compared.",
             beats_checked);
    if (fail_count == 0)
      $display("lz_rle_token_decompressor_top: match");
    else
      $display("lz_rle_token_decompressor_top: mismatch");
    $finish;
  end

endmodule
